[design/vsps_pkg.sv]
// ----------------------------------------------------------------------------
// vsps_pkg
// Shared types and constants of the vsync strobe PWM gate: register map,
// mode codes, reset values and the structs passed between the modules.
// ----------------------------------------------------------------------------
package vsps_pkg;

  // Field widths as seen on the ports and in the register file.
  localparam int MODE_W  = 2;
  localparam int FIELD_W = 16;
  localparam int DUTY_W  = 12;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int IDX_W   = 3;

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_PERIOD      = 3'd1,
    REG_PULSE_START = 3'd2,
    REG_PULSE_END   = 3'd3,
    REG_PWM_DUTY    = 3'd4
  } reg_idx_t;

  // Mode codes. The unused code behaves as autostart.
  localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VSYNC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO     = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0]  RST_MODE        = MODE_VSYNC;
  localparam logic [FIELD_W-1:0] RST_PERIOD      = 16'hFFFF;
  localparam logic [FIELD_W-1:0] RST_PULSE_START = 16'd0;
  localparam logic [FIELD_W-1:0] RST_PULSE_END   = 16'd1;
  localparam logic [DUTY_W-1:0]  RST_PWM_DUTY    = 12'd0;

  // Effective compare settings, already clamped.
  typedef struct packed {
    logic               one_shot;
    logic [FIELD_W-1:0] per_eff;
    logic [FIELD_W-1:0] start_eff;
    logic [FIELD_W-1:0] end_eff;
    logic [DUTY_W-1:0]  duty;
  } cfg_t;

  // A write to the mode register restarts the strobe counter.
  typedef struct packed {
    logic wr;
    logic run;
  } mode_wr_t;

  // One result transaction.
  typedef struct packed {
    logic               pwm_pin;
    logic               gate_open;
    logic [FIELD_W-1:0] strobe_count;
    logic               running;
  } result_t;

endpackage

[design/vsps_in_if.sv]
// ----------------------------------------------------------------------------
// vsps_in_if
// Input channel: one transaction per timer clock, carrying the vsync edge
// flag and the prescaled strobe tick.
// ----------------------------------------------------------------------------
interface vsps_in_if;
  logic valid;
  logic ready;
  logic vsync_rise;
  logic strobe_tick;

  modport source (output valid, output vsync_rise, output strobe_tick, input ready);
  modport sink   (input valid, input vsync_rise, input strobe_tick, output ready);
endinterface

[design/vsps_out_if.sv]
// ----------------------------------------------------------------------------
// vsps_out_if
// Result channel: pin level, strobe window flag, strobe count and run flag
// after each input transaction.
// ----------------------------------------------------------------------------
interface vsps_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_pin;
  logic        gate_open;
  logic [15:0] strobe_count;
  logic        running;

  modport source (output valid, output pwm_pin, output gate_open, output strobe_count,
                  output running, input ready);
  modport sink   (input valid, input pwm_pin, input gate_open, input strobe_count,
                  input running, output ready);
endinterface

[design/vsps_cfg.sv]
// ----------------------------------------------------------------------------
// vsps_cfg
// APB register file. Holds the five settings, clamps the compare values and
// flags a write to the mode register.
// ----------------------------------------------------------------------------
module vsps_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsps_pkg::ADDR_W-1:0]   paddr,
  input  logic [vsps_pkg::DATA_W-1:0]   pwdata,
  output logic [vsps_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output vsps_pkg::cfg_t                cfg,
  output vsps_pkg::mode_wr_t            mode_wr
);
  import vsps_pkg::*;

  logic [MODE_W-1:0]  mode_r;
  logic [FIELD_W-1:0] period_r;
  logic [FIELD_W-1:0] pulse_start_r;
  logic [FIELD_W-1:0] pulse_end_r;
  logic [DUTY_W-1:0]  pwm_duty_r;
  logic               wr_en;
  reg_idx_t           idx;
  logic [FIELD_W-1:0] end_min;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= RST_MODE;
      period_r      <= RST_PERIOD;
      pulse_start_r <= RST_PULSE_START;
      pulse_end_r   <= RST_PULSE_END;
      pwm_duty_r    <= RST_PWM_DUTY;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:        mode_r        <= pwdata[MODE_W-1:0];
        REG_PERIOD:      period_r      <= pwdata[FIELD_W-1:0];
        REG_PULSE_START: pulse_start_r <= pwdata[FIELD_W-1:0];
        REG_PULSE_END:   pulse_end_r   <= pwdata[FIELD_W-1:0];
        REG_PWM_DUTY:    pwm_duty_r    <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MODE:        prdata = DATA_W'(mode_r);
      REG_PERIOD:      prdata = DATA_W'(period_r);
      REG_PULSE_START: prdata = DATA_W'(pulse_start_r);
      REG_PULSE_END:   prdata = DATA_W'(pulse_end_r);
      REG_PWM_DUTY:    prdata = DATA_W'(pwm_duty_r);
      default:         prdata = '0;
    endcase
  end

  // Clamp: period at least one, end within 1..period, start within 0..end.
  always_comb begin
    cfg.one_shot = (mode_r == MODE_ONE_SHOT);
    cfg.duty     = pwm_duty_r;
    cfg.per_eff  = (period_r == '0) ? FIELD_W'(1) : period_r;
    end_min      = (pulse_end_r == '0) ? FIELD_W'(1) : pulse_end_r;
    cfg.end_eff  = (end_min > cfg.per_eff) ? cfg.per_eff : end_min;
    cfg.start_eff = (pulse_start_r > cfg.end_eff) ? cfg.end_eff : pulse_start_r;
  end

  // Mode write: the counter restarts unless the new mode waits for vsync.
  assign mode_wr.wr  = wr_en && (idx == REG_MODE);
  assign mode_wr.run = (pwdata[MODE_W-1:0] != MODE_VSYNC);

endmodule

[design/vsps_core.sv]
// ----------------------------------------------------------------------------
// vsps_core
// Strobe counter, window gate and PWM counter. Works out the next state for
// one transaction in a single pass and presents it as the result.
// ----------------------------------------------------------------------------
module vsps_core #(
  parameter int COUNTER_BITS = 16,
  parameter int PWM_BITS     = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                vsync_rise,
  input  logic                strobe_tick,
  input  vsps_pkg::cfg_t      cfg,
  input  vsps_pkg::mode_wr_t  mode_wr,
  output vsps_pkg::result_t   res
);
  import vsps_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > FIELD_W) ? COUNTER_BITS : FIELD_W;
  localparam int PWC_W = (PWM_BITS > DUTY_W) ? PWM_BITS : DUTY_W;

  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic                    run_r, run_nxt;
  logic                    gate_r, gate_nxt;
  logic [PWM_BITS-1:0]     pwm_r, pwm_nxt;
  logic                    pwm_high;
  logic                    moved;
  logic [CMP_W-1:0]        cnt_ext;
  logic [CMP_W-1:0]        new_ext;

  assign cnt_ext  = CMP_W'(cnt_r);
  assign pwm_high = PWC_W'(pwm_r) < PWC_W'(cfg.duty);
  assign pwm_nxt  = pwm_r + PWM_BITS'(1);

  // Counter step and compare checks for one transaction.
  always_comb begin
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    gate_nxt = gate_r;
    moved    = 1'b0;
    if (vsync_rise) begin
      cnt_nxt = '0;
      run_nxt = 1'b1;
      moved   = 1'b1;
    end else if (run_r && strobe_tick) begin
      moved = 1'b1;
      if (cnt_ext == CMP_W'(cfg.per_eff)) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + COUNTER_BITS'(1);
      end
    end
    new_ext = CMP_W'(cnt_nxt);
    if (moved && (new_ext == CMP_W'(cfg.start_eff))) begin
      gate_nxt = 1'b1;
    end
    if (moved && (new_ext == CMP_W'(cfg.end_eff))) begin
      gate_nxt = 1'b0;
      if (cfg.one_shot) begin
        run_nxt = 1'b0;
      end
    end
  end

  // State registers; a mode write clears the counter and may start it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run_r  <= 1'b0;
      gate_r <= 1'b0;
      pwm_r  <= '0;
    end else if (mode_wr.wr) begin
      cnt_r  <= '0;
      run_r  <= mode_wr.run;
      gate_r <= mode_wr.run && (cfg.start_eff == '0);
    end else if (step_en) begin
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      gate_r <= gate_nxt;
      pwm_r  <= pwm_nxt;
    end
  end

  // Result as seen after this transaction's update.
  assign res.pwm_pin      = gate_nxt && pwm_high;
  assign res.gate_open    = gate_nxt;
  assign res.strobe_count = new_ext[FIELD_W-1:0];
  assign res.running      = run_nxt;

endmodule

[design/vsync_strobe_pwm_gate.sv]
// ----------------------------------------------------------------------------
// vsync_strobe_pwm_gate
// Backlight strobe generator: vsync-restarted strobe window timer gating a
// free-running PWM, with an APB register file.
// ----------------------------------------------------------------------------
// One input transaction is taken every clock while the result side keeps up;
// each is one tick of the timer. A transaction passes an input register, the
// single-pass state update, and a result register, and the result register
// lets a new transaction in while a finished one waits. Registers must be
// written only while no transaction is in flight; the block itself does not
// enforce this. A mode write restarts the strobe counter.
module vsync_strobe_pwm_gate #(
  parameter int COUNTER_BITS = 16,
  parameter int PWM_BITS     = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  vsps_in_if.sink                      in_chan,
  vsps_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vsps_pkg::ADDR_W-1:0]  paddr,
  input  logic [vsps_pkg::DATA_W-1:0]  pwdata,
  output logic [vsps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import vsps_pkg::*;

  cfg_t     cfg;
  mode_wr_t mode_wr;
  result_t  res;
  result_t  out_r;
  logic     s1_valid_r, s1_vsync_r, s1_tick_r;
  logic     out_valid_r;
  logic     out_free;
  logic     step_en;
  logic     in_take;

  vsps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .mode_wr (mode_wr)
  );

  vsps_core #(
    .COUNTER_BITS (COUNTER_BITS),
    .PWM_BITS     (PWM_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .vsync_rise  (s1_vsync_r),
    .strobe_tick (s1_tick_r),
    .cfg         (cfg),
    .mode_wr     (mode_wr),
    .res         (res)
  );

  // Handshake: the input stage moves on whenever the result register is free.
  assign out_free      = !out_valid_r || out_chan.ready;
  assign step_en       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_take       = in_chan.valid && in_chan.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step_en) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_vsync_r <= in_chan.vsync_rise;
      s1_tick_r  <= in_chan.strobe_tick;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pwm_pin      = out_r.pwm_pin;
  assign out_chan.gate_open    = out_r.gate_open;
  assign out_chan.strobe_count = out_r.strobe_count;
  assign out_chan.running      = out_r.running;

`ifndef SYNTHESIS
  // The strobe window is only ever open while the counter runs.
  a_gate_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.gate_open |-> out_r.running)
    else $error("strobe gate open while counter stopped");

  // A vsync edge restarts the counter from zero and sets it running.
  a_vsync_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && s1_vsync_r |=> out_r.strobe_count == '0 && out_r.running)
    else $error("vsync did not restart the strobe counter");

  // Input is held off only when both stages are occupied.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");
`endif

endmodule
